[hw/rtl/assert_macros.svh]
// assertion helpers for the wipe block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SWT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define SWT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define SWT_ASSERT(lbl, clk, rstn, prop)
`define SWT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[hw/rtl/swt_pkg.sv]
package swt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_WIDTH     = 4096;
    localparam int EDGE_CAP      = 512;

    localparam int POS_W  = 13;
    localparam int COL_W  = 12;
    localparam int EDGE_W = 10;
    localparam int GLOW_W = 8;
    localparam int PIX_W  = 8;
    localparam int Q_W    = 9;
    localparam int NUM_W  = 18;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  width;
        logic [EDGE_W-1:0] edge_w;
        logic [GLOW_W-1:0] glow;
    } t_wipe_state;

endpackage

[hw/rtl/swt_in_if.sv]
interface swt_in_if import swt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [POS_W-1:0]  speed_target;
    logic              restart_level;
    logic [EDGE_W-1:0] edge_target;
    logic [GLOW_W-1:0] glow_target;
    logic [COL_W-1:0]  column;
    logic [PIX_W-1:0]  luma_a;
    logic [PIX_W-1:0]  cb_a;
    logic [PIX_W-1:0]  cr_a;
    logic [PIX_W-1:0]  luma_b;
    logic [PIX_W-1:0]  cb_b;
    logic [PIX_W-1:0]  cr_b;

    modport source (
        output valid, action, speed_target, restart_level, edge_target, glow_target,
        output column, luma_a, cb_a, cr_a, luma_b, cb_b, cr_b,
        input  ready
    );
    modport sink (
        input  valid, action, speed_target, restart_level, edge_target, glow_target,
        input  column, luma_a, cb_a, cr_a, luma_b, cb_b, cr_b,
        output ready
    );
endinterface

[hw/rtl/swt_out_if.sv]
interface swt_out_if import swt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_luma;
    logic [PIX_W-1:0] out_cb;
    logic [PIX_W-1:0] out_cr;
    logic             completed;
    logic [POS_W-1:0] wipe_column;

    modport source (
        output valid, out_luma, out_cb, out_cr, completed, wipe_column,
        input  ready
    );
    modport sink (
        input  valid, out_luma, out_cb, out_cr, completed, wipe_column,
        output ready
    );
endinterface

[hw/rtl/soft_edge_wipe_transition_unit.sv]
// Soft-edge left-to-right wipe for 4:4:4 YCbCr. Pixel beats stream at one per clock,
// unless the sequencer is busy or the output stalls, through a six-stage pipeline
// (input register, edge test, three stages of a radix-8 divider for the blend weight,
// then blend, glow and output register). A frame-start beat holds the input while the
// envelope sequencer (difference, multiply, accumulate, position update, issue) runs;
// pixels accepted afterwards see the new position, edge band and glow. frame_width is
// written through i_cfg_we; the user must write it only while idle, as the block itself
// does not enforce this.
module soft_edge_wipe_transition_unit import swt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [POS_W-1:0] i_cfg_wdata,
    swt_in_if.sink           i_in,
    swt_out_if.source        o_out
);

    logic        busy, emit, free, take, start, load;
    t_wipe_state st;

    assign i_in.ready = !busy && free;
    assign start = i_in.valid && i_in.ready && (i_in.action == ACT_FRAME);
    assign take  = emit && free;
    assign load  = (i_in.valid && i_in.ready && (i_in.action == ACT_PIXEL)) || take;

    swt_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (start),
        .i_speed_target  (i_in.speed_target),
        .i_restart_level (i_in.restart_level),
        .i_edge_target   (i_in.edge_target),
        .i_glow_target   (i_in.glow_target),
        .i_emit_take     (take),
        .o_busy          (busy),
        .o_emit          (emit),
        .o_state         (st)
    );

    swt_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_action (take ? ACT_FRAME : ACT_PIXEL),
        .i_column (i_in.column),
        .i_luma_a (i_in.luma_a),
        .i_cb_a   (i_in.cb_a),
        .i_cr_a   (i_in.cr_a),
        .i_luma_b (i_in.luma_b),
        .i_cb_b   (i_in.cb_b),
        .i_cr_b   (i_in.cr_b),
        .i_state  (st),
        .o_free   (free),
        .o_out    (o_out)
    );

endmodule

[hw/rtl/swt_seq.sv]
`include "assert_macros.svh"

module swt_seq import swt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [POS_W-1:0]  i_cfg_wdata,
    input  logic              i_start,
    input  logic [POS_W-1:0]  i_speed_target,
    input  logic              i_restart_level,
    input  logic [EDGE_W-1:0] i_edge_target,
    input  logic [GLOW_W-1:0] i_glow_target,
    input  logic              i_emit_take,
    output logic              o_busy,
    output logic              o_emit,
    output t_wipe_state       o_state
);

    localparam int SW  = POS_W + FRAC_BITS;
    localparam int EW  = EDGE_W + FRAC_BITS;
    localparam int GW  = GLOW_W + FRAC_BITS;
    localparam int CW  = FRAC_BITS - 1;
    localparam int SPW = SW + CW;
    localparam int EPW = EW + CW;
    localparam int GPW = GW + CW;
    localparam longint unsigned HALF = 64'd1 << (FRAC_BITS - 1);

    localparam logic [CW-1:0] C_SU = CW'(((64'd340 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [CW-1:0] C_SD = CW'(((64'd115 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [CW-1:0] C_EU = CW'(((64'd300 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [CW-1:0] C_ED = CW'(((64'd105 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [CW-1:0] C_GU = CW'(((64'd380 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [CW-1:0] C_GD = CW'(((64'd130 << FRAC_BITS) + 64'd500) / 64'd1000);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIFF = 6'b000010,
        S_MUL  = 6'b000100,
        S_ACC  = 6'b001000,
        S_POS  = 6'b010000,
        S_EMIT = 6'b100000
    } t_seq_state;

    t_seq_state r_state, n_state;

    logic [POS_W-1:0]  r_fw, r_pos;
    logic              r_prev_rs, r_primed;
    logic [SW-1:0]     r_env_s, r_mag_s;
    logic [EW-1:0]     r_env_e, r_mag_e;
    logic [GW-1:0]     r_env_g, r_mag_g;
    logic              r_up_s, r_up_e, r_up_g;
    logic [SPW-1:0]    r_prod_s;
    logic [EPW-1:0]    r_prod_e;
    logic [GPW-1:0]    r_prod_g;
    logic [EDGE_W-1:0] r_edge;
    logic [GLOW_W-1:0] r_glow;
    logic [POS_W-1:0]  r_st;
    logic [EDGE_W-1:0] r_et;
    logic [GLOW_W-1:0] r_gt;
    logic              r_rs;

    logic [POS_W-1:0]  c_w;
    logic [SW-1:0]     c_ts, c_es, c_step_s;
    logic [EW-1:0]     c_te, c_ee, c_step_e;
    logic [GW-1:0]     c_tg, c_eg, c_step_g;
    logic [POS_W-1:0]  c_rnd_s, c_sp, c_rnd_e, c_e1, c_e2;
    logic [POS_W:0]    c_sum;
    logic [GLOW_W:0]   c_rnd_g;

    always_comb begin
        c_w = (r_fw > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : r_fw;
        c_ts = SW'(r_st) << FRAC_BITS;
        c_te = EW'(r_et) << FRAC_BITS;
        c_tg = GW'(r_gt) << FRAC_BITS;
        c_es = r_primed ? r_env_s : c_ts;
        c_ee = r_primed ? r_env_e : c_te;
        c_eg = r_primed ? r_env_g : c_tg;
        c_step_s = SW'(({1'b0, r_prod_s} + (SPW+1)'(HALF)) >> FRAC_BITS);
        c_step_e = EW'(({1'b0, r_prod_e} + (EPW+1)'(HALF)) >> FRAC_BITS);
        c_step_g = GW'(({1'b0, r_prod_g} + (GPW+1)'(HALF)) >> FRAC_BITS);
        c_rnd_s = POS_W'(({1'b0, r_env_s} + (SW+1)'(HALF)) >> FRAC_BITS);
        c_rnd_e = POS_W'(({1'b0, r_env_e} + (EW+1)'(HALF)) >> FRAC_BITS);
        c_rnd_g = (GLOW_W+1)'(({1'b0, r_env_g} + (GW+1)'(HALF)) >> FRAC_BITS);
        c_sp = (c_rnd_s > c_w) ? c_w : c_rnd_s;
        c_sum = {1'b0, r_pos} + {1'b0, c_sp};
        c_e1 = (c_rnd_e > POS_W'(EDGE_CAP)) ? POS_W'(EDGE_CAP) : c_rnd_e;
        c_e2 = (c_e1 > c_w) ? c_w : c_e1;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_DIFF;
            S_DIFF: n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = S_POS;
            S_POS:  n_state = S_EMIT;
            S_EMIT: if (i_emit_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fw      <= POS_W'(720);
            r_pos     <= '0;
            r_prev_rs <= 1'b1;
            r_primed  <= 1'b0;
            r_env_s   <= '0;
            r_env_e   <= '0;
            r_env_g   <= '0;
            r_edge    <= '0;
            r_glow    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_fw <= i_cfg_wdata;
            end
            case (r_state)
                S_DIFF: begin
                    r_env_s   <= c_es;
                    r_env_e   <= c_ee;
                    r_env_g   <= c_eg;
                    r_primed  <= 1'b1;
                    r_prev_rs <= r_rs;
                    if (r_rs && !r_prev_rs) begin
                        r_pos <= '0;
                    end
                end
                S_ACC: begin
                    r_env_s <= r_up_s ? r_env_s + c_step_s : r_env_s - c_step_s;
                    r_env_e <= r_up_e ? r_env_e + c_step_e : r_env_e - c_step_e;
                    r_env_g <= r_up_g ? r_env_g + c_step_g : r_env_g - c_step_g;
                end
                S_POS: begin
                    r_pos  <= (c_sum > {1'b0, c_w}) ? c_w : POS_W'(c_sum);
                    r_edge <= EDGE_W'(c_e2);
                    r_glow <= (c_rnd_g > (GLOW_W+1)'(255)) ? GLOW_W'(255) : GLOW_W'(c_rnd_g);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_st <= i_speed_target;
            r_et <= i_edge_target;
            r_gt <= i_glow_target;
            r_rs <= i_restart_level;
        end
        if (r_state == S_DIFF) begin
            r_up_s  <= c_ts > c_es;
            r_up_e  <= c_te > c_ee;
            r_up_g  <= c_tg > c_eg;
            r_mag_s <= (c_ts > c_es) ? c_ts - c_es : c_es - c_ts;
            r_mag_e <= (c_te > c_ee) ? c_te - c_ee : c_ee - c_te;
            r_mag_g <= (c_tg > c_eg) ? c_tg - c_eg : c_eg - c_tg;
        end
        if (r_state == S_MUL) begin
            r_prod_s <= SPW'(r_mag_s) * SPW'(r_up_s ? C_SU : C_SD);
            r_prod_e <= EPW'(r_mag_e) * EPW'(r_up_e ? C_EU : C_ED);
            r_prod_g <= GPW'(r_mag_g) * GPW'(r_up_g ? C_GU : C_GD);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_emit = (r_state == S_EMIT);
    assign o_state.pos    = r_pos;
    assign o_state.width  = c_w;
    assign o_state.edge_w = r_edge;
    assign o_state.glow   = r_glow;

    `SWT_NEVER(a_start_busy, i_clk, i_rst_n, o_busy && i_start)
    `SWT_ASSERT(a_pos_in_width, i_clk, i_rst_n, (r_state == S_EMIT) |-> (r_pos <= c_w))
    `SWT_ASSERT(a_edge_max, i_clk, i_rst_n, (r_state == S_EMIT) |-> (13'(r_edge) <= c_w))

endmodule

[hw/rtl/swt_pipe.sv]
`include "assert_macros.svh"

module swt_pipe import swt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_action,
    input  logic [COL_W-1:0] i_column,
    input  logic [PIX_W-1:0] i_luma_a,
    input  logic [PIX_W-1:0] i_cb_a,
    input  logic [PIX_W-1:0] i_cr_a,
    input  logic [PIX_W-1:0] i_luma_b,
    input  logic [PIX_W-1:0] i_cb_b,
    input  logic [PIX_W-1:0] i_cr_b,
    input  t_wipe_state      i_state,
    output logic             o_free,
    swt_out_if.source        o_out
);

    function automatic logic [NUM_W+2:0] f_div3(input logic [NUM_W-1:0] rem,
                                                input logic [EDGE_W-1:0] dv,
                                                input int hi);
        logic [NUM_W-1:0] r;
        logic [NUM_W-1:0] sh;
        logic [2:0]       qb;
        r  = rem;
        qb = '0;
        for (int k = 0; k < 3; k++) begin
            sh = NUM_W'(dv) << (hi - k);
            if (r >= sh) begin
                r = r - sh;
                qb[2-k] = 1'b1;
            end
        end
        return {r, qb};
    endfunction

    function automatic logic [PIX_W-1:0] f_blend(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic [Q_W-1:0] q);
        logic [16:0] s;
        s = 17'(a) * 17'(Q_W'(256) - q) + 17'(b) * 17'(q) + 17'd128;
        return PIX_W'(s >> 8);
    endfunction

    // pixel beat payload, carried stage to stage
    typedef struct packed {
        logic             act;
        logic [PIX_W-1:0] la, ca, ra, lb, cb, rb;
        logic [POS_W-1:0] pos;
        logic             comp;
    } t_beat;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    t_beat             r_b2, r_b3, r_b4, r_b5;
    logic              r_act1;
    logic [COL_W-1:0]  r_col1;
    logic [PIX_W-1:0]  r_la1, r_ca1, r_ra1, r_lb1, r_cb1, r_rb1;
    t_wipe_state       r_st1;
    logic              r_inb2, r_inb3, r_inb4, r_inb5;
    logic              r_ine2, r_ine3, r_ine4, r_ine5;
    logic [EDGE_W-1:0] r_e2, r_e3, r_e4, r_e5;
    logic [GLOW_W-1:0] r_g2, r_g3, r_g4, r_g5;
    logic [NUM_W-1:0]  r_rem2, r_rem3, r_rem4, r_rem5;
    logic [Q_W-1:0]    r_q3, r_q4, r_q5;
    logic [PIX_W-1:0]  r_ol6, r_ob6, r_or6;
    logic              r_comp6;
    logic [POS_W-1:0]  r_pos6;

    logic              c_inb, c_ine;
    logic [POS_W:0]    c_end;
    logic [POS_W-1:0]  c_rel;
    logic [EDGE_W-1:0] c_d;
    logic [NUM_W-1:0]  c_num;
    logic [NUM_W+2:0]  c_d3, c_d4, c_d5;
    logic [PIX_W-1:0]  c_bl, c_bb, c_br;
    logic [16:0]       c_gp;
    logic [PIX_W:0]    c_lum;
    logic [PIX_W-1:0]  c_ol, c_ob, c_or;

    assign en6 = !r_v6 || o_out.ready;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_free = en1;

    always_comb begin
        c_inb = {1'b0, r_col1} < r_st1.pos;
        c_end = {1'b0, r_st1.pos} + (POS_W+1)'(r_st1.edge_w);
        c_ine = (r_st1.edge_w != '0) && ({1'b0, r_col1} < r_st1.width)
                && ((POS_W+1)'(r_col1) < c_end);
        c_rel = {1'b0, r_col1} - r_st1.pos;
        c_d   = r_st1.edge_w - EDGE_W'(c_rel);
        c_num = (NUM_W'(c_d) << 8) + NUM_W'(r_st1.edge_w >> 1);
        c_d3  = f_div3(r_rem2, r_e2, 8);
        c_d4  = f_div3(r_rem3, r_e3, 5);
        c_d5  = f_div3(r_rem4, r_e4, 2);
        c_bl  = f_blend(r_b5.la, r_b5.lb, r_q5);
        c_bb  = f_blend(r_b5.ca, r_b5.cb, r_q5);
        c_br  = f_blend(r_b5.ra, r_b5.rb, r_q5);
        c_gp  = 17'(r_g5) * 17'(r_q5) + 17'd128;
        c_lum = (PIX_W+1)'(c_bl) + (PIX_W+1)'(c_gp >> 8);
        c_ol  = r_b5.la;
        c_ob  = r_b5.ca;
        c_or  = r_b5.ra;
        if (r_b5.act == ACT_FRAME) begin
            c_ol = '0;
            c_ob = '0;
            c_or = '0;
        end else if (r_inb5) begin
            c_ol = r_b5.lb;
            c_ob = r_b5.cb;
            c_or = r_b5.rb;
        end else if (r_ine5) begin
            c_ol = c_lum[PIX_W] ? PIX_W'(255) : c_lum[PIX_W-1:0];
            c_ob = c_bb;
            c_or = c_br;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_load;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_act1 <= i_action;
            r_col1 <= i_column;
            r_la1  <= i_luma_a;
            r_ca1  <= i_cb_a;
            r_ra1  <= i_cr_a;
            r_lb1  <= i_luma_b;
            r_cb1  <= i_cb_b;
            r_rb1  <= i_cr_b;
            r_st1  <= i_state;
        end
        if (en2) begin
            r_b2   <= '{act: r_act1, la: r_la1, ca: r_ca1, ra: r_ra1,
                        lb: r_lb1, cb: r_cb1, rb: r_rb1, pos: r_st1.pos,
                        comp: (r_st1.pos >= r_st1.width)};
            r_inb2 <= c_inb;
            r_ine2 <= c_ine;
            r_e2   <= r_st1.edge_w;
            r_g2   <= r_st1.glow;
            r_rem2 <= c_num;
        end
        if (en3) begin
            r_b3   <= r_b2;
            r_inb3 <= r_inb2;
            r_ine3 <= r_ine2;
            r_e3   <= r_e2;
            r_g3   <= r_g2;
            r_rem3 <= c_d3[NUM_W+2:3];
            r_q3   <= {c_d3[2:0], 6'b0};
        end
        if (en4) begin
            r_b4   <= r_b3;
            r_inb4 <= r_inb3;
            r_ine4 <= r_ine3;
            r_e4   <= r_e3;
            r_g4   <= r_g3;
            r_rem4 <= c_d4[NUM_W+2:3];
            r_q4   <= {r_q3[8:6], c_d4[2:0], 3'b0};
        end
        if (en5) begin
            r_b5   <= r_b4;
            r_inb5 <= r_inb4;
            r_ine5 <= r_ine4;
            r_e5   <= r_e4;
            r_g5   <= r_g4;
            r_rem5 <= c_d5[NUM_W+2:3];
            r_q5   <= {r_q4[8:3], c_d5[2:0]};
        end
        if (en6) begin
            r_ol6   <= c_ol;
            r_ob6   <= c_ob;
            r_or6   <= c_or;
            r_comp6 <= r_b5.comp;
            r_pos6  <= r_b5.pos;
        end
    end

    assign o_out.valid       = r_v6;
    assign o_out.out_luma    = r_ol6;
    assign o_out.out_cb      = r_ob6;
    assign o_out.out_cr      = r_or6;
    assign o_out.completed   = r_comp6;
    assign o_out.wipe_column = r_pos6;

    `SWT_ASSERT(a_rem_first, i_clk, i_rst_n, (r_v3 && r_ine3 && !r_inb3 && r_b3.act) |-> (r_rem3 < (18'(r_e3) << 6)))
    `SWT_ASSERT(a_rem_last, i_clk, i_rst_n, (r_v5 && r_ine5 && !r_inb5 && r_b5.act) |-> (r_rem5 < 18'(r_e5)))
    `SWT_ASSERT(a_q_bound, i_clk, i_rst_n, (r_v5 && r_ine5 && !r_inb5 && r_b5.act) |-> (r_q5 <= 9'd256))

endmodule
